// ===== hdl/radius_point_dedup_top_assert.svh =====
// assertion macros for the radius point dedup top level
// expects clk and rst in the scope where a macro is used
`ifndef RADIUS_POINT_DEDUP_TOP_ASSERT_SVH
`define RADIUS_POINT_DEDUP_TOP_ASSERT_SVH

// same-cycle implication
`define RPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rpd_pkg.sv =====
// shared constants and controller/datapath handshake types for radius point dedup
// no dependencies
`timescale 1ns / 1ps

package rpd_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_W     = 24;
  localparam int RADIUS_W    = 16;
  localparam int R2_W        = 2 * RADIUS_W;
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W      = $clog2(2 * MAX_POINTS);
  localparam int COUNT_OUT_W = 7;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int SQ_W        = 2 * DIFF_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int ENTRY_W     = 3 * COORD_W;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(200);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } rpd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic pipe_empty;
    logic out_free;
  } rpd_sts_t;

endpackage

// ===== hdl/rpd_if.sv =====
// valid/ready channel interfaces: point input, result output, radius config
// depends on rpd_pkg
`timescale 1ns / 1ps

interface rpd_in_if import rpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               side;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [COORD_W-1:0] point_z;
  logic               frame_end;

  modport source (output valid, side, point_x, point_y, point_z, frame_end, input ready);
  modport sink   (input valid, side, point_x, point_y, point_z, frame_end, output ready);
endinterface

interface rpd_out_if import rpd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   out_side;
  logic                   kept;
  logic [COORD_W-1:0]     out_x;
  logic [COORD_W-1:0]     out_y;
  logic [COORD_W-1:0]     out_z;
  logic [COUNT_OUT_W-1:0] kept_count;
  logic                   overflow;
  logic                   last_of_frame;

  modport source (output valid, out_side, kept, out_x, out_y, out_z, kept_count, overflow,
                  last_of_frame, input ready);
  modport sink   (input valid, out_side, kept, out_x, out_y, out_z, kept_count, overflow,
                  last_of_frame, output ready);
endinterface

interface rpd_cfg_if import rpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] merge_radius;

  modport source (output valid, merge_radius, input ready);
  modport sink   (input valid, merge_radius, output ready);
endinterface

// ===== hdl/rpd_ctrl.sv =====
// sequencing state machine: accept, scan kept points, drain, commit result
// depends on rpd_pkg
`timescale 1ns / 1ps

module rpd_ctrl import rpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  rpd_sts_t sts,
  output rpd_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DECIDE = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.issue  = (state == S_SCAN) && !sts.scan_done;
  assign cmd.commit = (state == S_DECIDE) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        // wait for the last compare to land
        if (sts.pipe_empty) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/rpd_datapath.sv =====
// point store, distance pipeline, bank counts, radius register and result register
// depends on rpd_pkg and rpd_if
`timescale 1ns / 1ps

module rpd_datapath import rpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  rpd_cmd_t           cmd,
  output rpd_sts_t           sts,
  input  logic               in_side,
  input  logic [COORD_W-1:0] in_x,
  input  logic [COORD_W-1:0] in_y,
  input  logic [COORD_W-1:0] in_z,
  input  logic               in_last,
  rpd_cfg_if.sink            cfg,
  rpd_out_if.source          res
);

  logic [ENTRY_W-1:0]  mem [2*MAX_POINTS];
  logic [ENTRY_W-1:0]  rd_data;
  logic [RADIUS_W-1:0] radius;
  logic [R2_W-1:0]     r2;
  logic [COORD_W-1:0]  p_x, p_y, p_z;
  logic                p_side, p_last;
  logic [CNT_W-1:0]    p_cnt;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    bank_cnt [2];
  logic                v1, v2;
  logic                near;
  logic [SQ_W-1:0]     sq_x, sq_y, sq_z;
  logic                out_valid;

  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [DIFF_W-1:0]   mag_x, mag_y, mag_z;
  logic [SUM_W-1:0]    dist2;
  logic                keep, ovf;
  logic [CNT_W-1:0]    cnt_after;

  function automatic logic [DIFF_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                 logic [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg.valid) begin
      radius <= cfg.merge_radius;
    end
  end

  assign base    = p_side ? ADDR_W'(MAX_POINTS) : '0;
  assign rd_addr = base + ADDR_W'(idx);
  assign wr_addr = base + ADDR_W'(p_cnt);

  // latched item and scan index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_side <= in_side;
      p_x    <= in_x;
      p_y    <= in_y;
      p_z    <= in_z;
      p_last <= in_last;
      p_cnt  <= bank_cnt[in_side];
      r2     <= R2_W'(radius) * R2_W'(radius);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= '0;
    end else if (cmd.issue) begin
      idx <= idx + CNT_W'(1);
    end
  end

  // point store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && keep) begin
      mem[wr_addr] <= {p_x, p_y, p_z};
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign mag_x = abs_diff(p_x, rd_data[3*COORD_W-1:2*COORD_W]);
  assign mag_y = abs_diff(p_y, rd_data[2*COORD_W-1:COORD_W]);
  assign mag_z = abs_diff(p_z, rd_data[COORD_W-1:0]);

  always_ff @(posedge clk) begin
    sq_x <= mag_x * mag_x;
    sq_y <= mag_y * mag_y;
    sq_z <= mag_z * mag_z;
  end

  assign dist2 = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      near <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      if (cmd.load) begin
        near <= 1'b0;
      end else if (v2 && (dist2 <= SUM_W'(r2))) begin
        near <= 1'b1;
      end
    end
  end

  assign keep      = !near && (p_cnt < CNT_W'(MAX_POINTS));
  assign ovf       = !near && !keep;
  assign cnt_after = keep ? p_cnt + CNT_W'(1) : p_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_cnt[0] <= '0;
      bank_cnt[1] <= '0;
    end else if (cmd.commit) begin
      bank_cnt[p_side] <= p_last ? '0 : cnt_after;
    end
  end

  // result register, frees the scan for the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res.out_side      <= p_side;
      res.kept          <= keep;
      res.out_x         <= p_x;
      res.out_y         <= p_y;
      res.out_z         <= p_z;
      res.kept_count    <= COUNT_OUT_W'(cnt_after);
      res.overflow      <= ovf;
      res.last_of_frame <= p_last;
    end
  end

  assign res.valid      = out_valid;
  assign sts.scan_done  = (idx == p_cnt);
  assign sts.pipe_empty = !v1 && !v2;
  assign sts.out_free   = !out_valid || res.ready;

endmodule

// ===== hdl/radius_point_dedup_top.sv =====
// Radius point dedup: each accepted point is compared against the points already
// kept in its bank (side), one stored point per cycle through a registered read,
// a squaring stage and a compare stage. A point farther than merge_radius from
// all of them is appended unless the bank already holds 64 points. One result
// per point. The result is registered once the scan over the point store, one read
// per cycle, has covered the bank's current kept points and the compare pipeline
// has drained. The block takes no new point until that result is committed to the
// output register. The next point is taken while a finished result still waits in
// the output register; a result that is still waiting when the next one is ready
// holds the block until it leaves. merge_radius (reset 200) may be written only
// while the block is idle.
// depends on rpd_pkg, rpd_if, rpd_ctrl, rpd_datapath and the assertion header
`timescale 1ns / 1ps

`include "radius_point_dedup_top_assert.svh"

module radius_point_dedup_top import rpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rpd_in_if.sink    pt_in,
  rpd_cfg_if.sink   cfg,
  rpd_out_if.source res_out
);

  rpd_cmd_t cmd;
  rpd_sts_t sts;
  logic     in_ready;

  assign pt_in.ready = in_ready;

  rpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pt_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpd_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .in_side (pt_in.side),
    .in_x    (pt_in.point_x),
    .in_y    (pt_in.point_y),
    .in_z    (pt_in.point_z),
    .in_last (pt_in.frame_end),
    .cfg     (cfg),
    .res     (res_out)
  );

  `RPD_ASSERT_NXT(a_busy_after_transfer, pt_in.valid && pt_in.ready, !pt_in.ready, "input taken while busy")
  `RPD_ASSERT_IMP(a_commit_after_drain, cmd.commit, sts.pipe_empty, "commit with compares in flight")
  `RPD_ASSERT_IMP(a_no_issue_past_count, cmd.issue, !sts.scan_done, "read issued past bank count")
  `RPD_ASSERT_IMP(a_kept_excludes_ovf, res_out.valid, !(res_out.kept && res_out.overflow), "kept and overflow together")

endmodule
